// File: hdl/gtb_pkg.sv
package gtb_pkg;

    // Pipelined divider geometry: one quotient bit per stage
    localparam int DIV_QW     = 10;
    localparam int DIV_NW     = 22;
    localparam int DIV_DW     = 12;

    // Word queue between front and back
    localparam int QDEPTH     = 32;
    localparam int Q_AW       = $clog2(QDEPTH);

    localparam int BN_W       = 192;

    // Register indexes
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_OPACITY   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    typedef enum logic [2:0] {
        MODE_ADD      = 3'd0,
        MODE_SCREEN   = 3'd1,
        MODE_SOFT     = 3'd2,
        MODE_FILMIC   = 3'd3,
        MODE_COMPRESS = 3'd4,
        MODE_ENERGY   = 3'd5
    } t_mode;

    typedef logic [255:0][9:0]  t_lin_rom;
    typedef logic [1023:0][7:0] t_inv_rom;

    // Classified word handed from front to back
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
        logic [7:0] mask;
        logic       above;
        logic [7:0] glow;
        logic       region;
        logic [9:0] lin;
    } t_pix;

    function automatic logic [BN_W-1:0] ipow(logic [BN_W-1:0] b, int e);
        logic [BN_W-1:0] r;
        r = 1;
        for (int j = 0; j < e; j++) begin
            r = r * b;
        end
        return r;
    endfunction

    // lin[i] = round(1023 * (i/255)^2.2), exact
    function automatic t_lin_rom build_lin();
        t_lin_rom        rom;
        logic [BN_W-1:0] rhs;
        logic [BN_W-1:0] lhs;
        int              lo;
        int              hi;
        int              mid;
        for (int i = 0; i < 256; i++) begin
            rhs = ipow(BN_W'(i), 11) * ipow(BN_W'(2046), 5);
            lo  = 0;
            hi  = 1023;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                lhs = ipow(BN_W'(2 * mid - 1), 5) * ipow(BN_W'(255), 11);
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            rom[i] = 10'(lo);
        end
        return rom;
    endfunction

    // inv[i] = round(255 * (i/1023)^(1/2.2)), exact
    function automatic t_inv_rom build_inv();
        t_inv_rom        rom;
        logic [BN_W-1:0] rhs;
        logic [BN_W-1:0] lhs;
        int              lo;
        int              hi;
        int              mid;
        for (int i = 0; i < 1024; i++) begin
            rhs = ipow(BN_W'(i), 5) * ipow(BN_W'(510), 11);
            lo  = 0;
            hi  = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                lhs = ipow(BN_W'(2 * mid - 1), 11) * ipow(BN_W'(1023), 5);
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            rom[i] = 8'(lo);
        end
        return rom;
    endfunction

    localparam t_lin_rom LIN_ROM = build_lin();
    localparam t_inv_rom INV_ROM = build_inv();

endpackage

// File: hdl/gtb_div.sv
// Restoring divider, one quotient bit per stage, advances on i_en.
// o_sat flags a quotient that does not fit DIV_QW bits.
module gtb_div import gtb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QW-1:0] o_quot,
    output logic              o_sat
);

    logic [DIV_NW-1:0] r_rem  [0:DIV_QW];
    logic [DIV_DW-1:0] r_den  [0:DIV_QW];
    logic [DIV_QW-1:0] r_quot [0:DIV_QW];
    logic              r_sat  [0:DIV_QW];

    logic [DIV_NW-1:0] w_sub [1:DIV_QW];
    logic              w_ge  [1:DIV_QW];

    always_comb begin
        for (int s = 1; s <= DIV_QW; s++) begin
            w_sub[s] = DIV_NW'(r_den[s-1]) << (DIV_QW - s);
            w_ge[s]  = r_rem[s-1] >= w_sub[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_quot[0] <= '0;
            r_sat[0]  <= i_num >= (DIV_NW'(i_den) << DIV_QW);
            for (int s = 1; s <= DIV_QW; s++) begin
                r_rem[s]  <= w_ge[s] ? r_rem[s-1] - w_sub[s] : r_rem[s-1];
                r_den[s]  <= r_den[s-1];
                r_quot[s] <= r_quot[s-1] | (w_ge[s] ? DIV_QW'(1) << (DIV_QW - s)
                                                    : DIV_QW'(0));
                r_sat[s]  <= r_sat[s-1];
            end
        end
    end

    assign o_quot = r_quot[DIV_QW];
    assign o_sat  = r_sat[DIV_QW];

endmodule

// File: hdl/gtb_front.sv
// Front: gamma lookup, threshold/knee/smoothstep mask, glow level.
// Free running; the top level keeps it from overrunning the queue.
module gtb_front import gtb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_luma,
    input  logic [7:0] i_cb,
    input  logic [7:0] i_cr,
    input  logic [7:0] i_bloom,
    input  logic       i_region,
    input  logic [7:0] i_threshold,
    input  logic [7:0] i_opacity,
    output logic       o_valid,
    output t_pix       o_item
);

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
        logic [7:0] bloom;
        logic       region;
        logic [9:0] lin;
        logic       pos;
    } t_fstage;

    // input stage
    logic    r_p1_valid;
    t_fstage r_p1;

    logic [10:0]       w_t;
    logic              w_pos;
    logic [9:0]        w_v;
    logic [DIV_NW-1:0] w_num;
    logic [9:0]        w_denom;
    logic [9:0]        w_knee;
    t_fstage           w_p1_pos;

    always_comb begin
        w_t     = {1'b0, i_threshold, 2'b00} + 11'd16;
        w_pos   = {1'b0, r_p1.lin} > w_t;
        w_v     = 10'({1'b0, r_p1.lin} - w_t);
        w_num   = w_pos ? DIV_NW'({w_v, 8'b0}) : '0;
        w_denom = 10'd1015 - {1'b0, i_threshold, 1'b0};
        w_knee  = {1'b0, i_threshold, 1'b0} + 10'd24;
        w_p1_pos     = r_p1;
        w_p1_pos.pos = w_pos;
    end

    logic [DIV_QW-1:0] w_xq_raw;
    logic [DIV_QW-1:0] w_kq_raw;
    logic              w_x_sat;
    logic              w_k_sat;

    gtb_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (1'b1),
        .i_num  (w_num),
        .i_den  (DIV_DW'(w_denom)),
        .o_quot (w_xq_raw),
        .o_sat  (w_x_sat)
    );

    gtb_div u_div_k (
        .i_clk  (i_clk),
        .i_en   (1'b1),
        .i_num  (w_num),
        .i_den  (DIV_DW'(w_knee)),
        .o_quot (w_kq_raw),
        .o_sat  (w_k_sat)
    );

    // delay line alongside the dividers
    logic    r_dv [0:DIV_QW];
    t_fstage r_dl [0:DIV_QW];

    // post-divide stages
    logic [8:0]  w_xq;
    logic [8:0]  w_kq;
    logic [17:0] w_xx;
    logic [10:0] w_x1;
    logic [26:0] w_smp;
    logic [18:0] w_xs;
    logic [8:0]  w_gsum;
    logic [7:0]  w_gcl;
    logic [15:0] w_gp;

    logic        r_e1_valid, r_e2_valid, r_e3_valid, r_e4_valid;
    t_fstage     r_e1, r_e2, r_e3;
    logic [9:0]  r_e1_x, r_e2_x;
    logic [16:0] r_e1_kk;
    logic [8:0]  r_e1_k;
    logic [8:0]  r_e2_smooth;
    logic [7:0]  r_e3_mask;
    t_pix        r_e4;

    always_comb begin
        w_xq   = (w_x_sat || w_xq_raw > 10'd320) ? 9'd320 : w_xq_raw[8:0];
        w_kq   = (w_k_sat || w_kq_raw > 10'd256) ? 9'd256 : w_kq_raw[8:0];
        w_xx   = 18'(w_xq) * 18'(w_xq);
        w_x1   = 11'(w_xq) + 11'(w_xx[17:8]);
        w_smp  = 27'(r_e1_kk) * 27'(10'd768 - {r_e1_k, 1'b0});
        w_xs   = 19'(r_e2_x) * 19'(r_e2_smooth);
        w_gsum = 9'(r_e3_mask) + 9'(r_e3.bloom);
        w_gcl  = w_gsum[8] ? 8'd255 : w_gsum[7:0];
        w_gp   = 16'(w_gcl) * 16'(i_opacity);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            for (int s = 0; s <= DIV_QW; s++) begin
                r_dv[s] <= 1'b0;
            end
            r_e1_valid <= 1'b0;
            r_e2_valid <= 1'b0;
            r_e3_valid <= 1'b0;
            r_e4_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_valid;
            r_dv[0]    <= r_p1_valid;
            for (int s = 1; s <= DIV_QW; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
            r_e1_valid <= r_dv[DIV_QW];
            r_e2_valid <= r_e1_valid;
            r_e3_valid <= r_e2_valid;
            r_e4_valid <= r_e3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1.y      <= i_luma;
        r_p1.cb     <= i_cb;
        r_p1.cr     <= i_cr;
        r_p1.bloom  <= i_bloom;
        r_p1.region <= i_region;
        r_p1.lin    <= LIN_ROM[i_luma];
        r_p1.pos    <= 1'b0;

        r_dl[0]     <= w_p1_pos;
        for (int s = 1; s <= DIV_QW; s++) begin
            r_dl[s] <= r_dl[s-1];
        end

        r_e1    <= r_dl[DIV_QW];
        r_e1_x  <= w_x1 > 11'd512 ? 10'd512 : w_x1[9:0];
        r_e1_kk <= 17'(18'(w_kq) * 18'(w_kq));
        r_e1_k  <= w_kq;

        r_e2        <= r_e1;
        r_e2_x      <= r_e1_x;
        r_e2_smooth <= w_smp[24:16];

        r_e3      <= r_e2;
        r_e3_mask <= w_xs[18:9] > 10'd255 ? 8'd255 : w_xs[16:9];

        r_e4.y      <= r_e3.y;
        r_e4.cb     <= r_e3.cb;
        r_e4.cr     <= r_e3.cr;
        r_e4.mask   <= r_e3_mask;
        r_e4.above  <= r_e3.pos;
        r_e4.glow   <= w_gp[15:8];
        r_e4.region <= r_e3.region;
        r_e4.lin    <= r_e3.lin;
    end

    assign o_valid = r_e4_valid;
    assign o_item  = r_e4;

endmodule

// File: hdl/gtb_fifo.sv
module gtb_fifo import gtb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_data,
    input  logic i_pop,
    output logic o_valid,
    output t_pix o_data
);

    t_pix          r_mem [0:QDEPTH-1];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

endmodule

// File: hdl/gtb_back.sv
// Back: blend modes, chroma push, inverse gamma, output register.
// Every stage moves together whenever the output register can take a word.
module gtb_back import gtb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_mode,
    input  logic       i_q_valid,
    input  t_pix       i_q_item,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_luma,
    output logic [7:0] o_cb,
    output logic [7:0] o_cr,
    output logic [7:0] o_mask,
    output logic       o_above
);

    typedef struct packed {
        t_pix               item;
        logic [10:0]        s;
        logic [19:0]        p_scr;
        logic [21:0]        p_sq;
        logic [19:0]        p_en;
        logic [15:0]        p_soft;
        logic signed [17:0] p_cb;
        logic signed [17:0] p_cr;
    } t_bstage;

    logic w_adv;
    logic r_out_valid;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_q_pop = w_adv && i_q_valid;

    logic       r_b0_valid;
    t_pix       r_b0;
    logic [9:0] r_b0_b;

    logic [10:0]        w_s;
    logic [9:0]         w_na;
    logic [9:0]         w_nb;
    logic signed [8:0]  w_ucb;
    logic signed [8:0]  w_ucr;
    logic signed [8:0]  w_g;
    t_bstage            w_bs;

    always_comb begin
        w_s        = 11'(r_b0.lin) + 11'(r_b0_b);
        w_na       = 10'd1023 - r_b0.lin;
        w_nb       = 10'd1023 - r_b0_b;
        w_ucb      = $signed({1'b0, r_b0.cb}) - 9'sd128;
        w_ucr      = $signed({1'b0, r_b0.cr}) - 9'sd128;
        w_g        = $signed({1'b0, r_b0.glow});
        w_bs.item  = r_b0;
        w_bs.s     = w_s;
        w_bs.p_scr = 20'(w_na) * 20'(w_nb);
        w_bs.p_sq  = 22'(w_s) * 22'(w_s);
        w_bs.p_en  = 20'(r_b0_b) * 20'(w_na);
        w_bs.p_soft = 16'(r_b0.y) * 16'(r_b0.glow);
        w_bs.p_cb  = 18'(w_ucb) * 18'(w_g);
        w_bs.p_cr  = 18'(w_ucr) * 18'(w_g);
    end

    // filmic divide: s*1024 / (s + 1023)
    logic [DIV_QW-1:0] w_fq;
    logic              w_fsat;

    gtb_div u_div_f (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (DIV_NW'({w_s, 10'b0})),
        .i_den  (DIV_DW'(w_s) + DIV_DW'(1023)),
        .o_quot (w_fq),
        .o_sat  (w_fsat)
    );

    logic    r_dv [0:DIV_QW];
    t_bstage r_dl [0:DIV_QW];

    // result stage
    t_bstage            w_e;
    logic [11:0]        w_r;
    logic [9:0]         w_soft;
    logic               w_soft_sel;
    logic               w_act;
    logic signed [10:0] w_cbv;
    logic signed [10:0] w_crv;

    always_comb begin
        w_e        = r_dl[DIV_QW];
        w_soft     = 10'(w_e.item.y) + 10'(w_e.item.glow) + 10'(w_e.p_soft[15:8]);
        w_soft_sel = 1'b0;
        unique case (i_mode)
            MODE_ADD:      w_r = 12'(w_e.s);
            MODE_SCREEN:   w_r = 12'(10'd1023 - w_e.p_scr[19:10]);
            MODE_SOFT: begin
                w_r        = '0;
                w_soft_sel = 1'b1;
            end
            MODE_FILMIC:   w_r = w_fsat ? 12'd1023 : 12'(w_fq);
            MODE_COMPRESS: w_r = 12'(w_e.s) - 12'(w_e.p_sq[21:11]);
            default:       w_r = 12'(w_e.item.lin) + 12'(w_e.p_en[19:10]);
        endcase
        w_act = w_e.item.region && (w_e.item.glow != 8'd0);
        w_cbv = 11'sd128 + 11'($signed({1'b0, w_e.item.cb}) - 9'sd128)
                + 11'(w_e.p_cb >>> 9);
        w_crv = 11'sd128 + 11'($signed({1'b0, w_e.item.cr}) - 9'sd128)
                + 11'(w_e.p_cr >>> 9);
    end

    logic       r_r_valid;
    t_pix       r_r;
    logic       r_r_act;
    logic       r_r_soft_sel;
    logic [7:0] r_r_soft;
    logic [9:0] r_r_idx;
    logic [7:0] r_r_cb;
    logic [7:0] r_r_cr;

    logic [7:0] r_o_luma, r_o_cb, r_o_cr, r_o_mask;
    logic       r_o_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid  <= 1'b0;
            for (int s = 0; s <= DIV_QW; s++) begin
                r_dv[s] <= 1'b0;
            end
            r_r_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b0_valid <= i_q_valid;
            r_dv[0]    <= r_b0_valid;
            for (int s = 1; s <= DIV_QW; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
            r_r_valid   <= r_dv[DIV_QW];
            r_out_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b0   <= i_q_item;
            r_b0_b <= LIN_ROM[i_q_item.glow];

            r_dl[0] <= w_bs;
            for (int s = 1; s <= DIV_QW; s++) begin
                r_dl[s] <= r_dl[s-1];
            end

            r_r          <= w_e.item;
            r_r_act      <= w_act;
            r_r_soft_sel <= w_soft_sel;
            r_r_soft     <= w_soft > 10'd255 ? 8'd255 : w_soft[7:0];
            r_r_idx      <= w_r > 12'd1023 ? 10'd1023 : w_r[9:0];
            r_r_cb       <= w_cbv < 0 ? 8'd0 : (w_cbv > 11'sd255 ? 8'd255 : w_cbv[7:0]);
            r_r_cr       <= w_crv < 0 ? 8'd0 : (w_crv > 11'sd255 ? 8'd255 : w_crv[7:0]);

            if (!r_r_act)          r_o_luma <= r_r.y;
            else if (r_r_soft_sel) r_o_luma <= r_r_soft;
            else                   r_o_luma <= INV_ROM[r_r_idx];
            r_o_cb    <= r_r_act ? r_r_cb : r_r.cb;
            r_o_cr    <= r_r_act ? r_r_cr : r_r.cr;
            r_o_mask  <= r_r.mask;
            r_o_above <= r_r.above;
        end
    end

    assign o_valid = r_out_valid;
    assign o_luma  = r_o_luma;
    assign o_cb    = r_o_cb;
    assign o_cr    = r_o_cr;
    assign o_mask  = r_o_mask;
    assign o_above = r_o_above;

endmodule

// File: hdl/glow_threshold_and_blend.sv
// Glow threshold and blend, one pixel per word.
// Input channel: i_in_valid / o_in_ready with luma, cb, cr, bloom sample
// and region flag. Output channel: o_out_valid / i_out_ready with blended
// luma, pushed chroma, mask level and above-threshold flag, one word out
// for every word in, in order.
// Config: i_cfg_we writes register i_cfg_index (0 blend mode, 1 opacity,
// 2 threshold) on the clock edge; write only while no word is in flight.
// Throughput: one word per clock while the receiver stays ready. Path from
// the accepting edge to o_out_valid: 16 front stages, 1 queue write, 14
// back stages, the first front stage loading on that edge; the 11-register restoring
// dividers, two in the front and one in the back, make up most of them.
// The front runs freely and writes a 32-word queue; o_in_ready drops
// only when words in the front plus the queue reach 32, so a receiver
// stall backs up the back pipeline, then the queue, then the input.
// Reset (synchronous, active low): pipelines and queue empty, blend mode
// additive, opacity 25, threshold 160. Gamma tables are constants.
module glow_threshold_and_blend import gtb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_luma_in,
    input  logic [7:0] i_cb_in,
    input  logic [7:0] i_cr_in,
    input  logic [7:0] i_bloom_sample,
    input  logic       i_in_region,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_luma_out,
    output logic [7:0] o_cb_out,
    output logic [7:0] o_cr_out,
    output logic [7:0] o_mask_level,
    output logic       o_above_threshold,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [2:0] r_mode;
    logic [7:0] r_opacity;
    logic [7:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ADD;
            r_opacity   <= 8'd25;
            r_threshold <= 8'd160;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:      r_mode      <= i_cfg_data[2:0];
                CFG_OPACITY:   r_opacity   <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // credits: words accepted but not yet popped from the queue
    logic          w_in_acc;
    logic          w_pop;
    logic [Q_AW:0] r_credit;
    logic [Q_AW:0] n_credit;

    assign o_in_ready = r_credit < (Q_AW+1)'(QDEPTH);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign n_credit   = r_credit + (Q_AW+1)'(w_in_acc) - (Q_AW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_credit <= '0;
        else          r_credit <= n_credit;
    end

    logic w_f_valid;
    t_pix w_f_item;
    logic w_q_valid;
    t_pix w_q_item;

    gtb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_acc),
        .i_luma      (i_luma_in),
        .i_cb        (i_cb_in),
        .i_cr        (i_cr_in),
        .i_bloom     (i_bloom_sample),
        .i_region    (i_in_region),
        .i_threshold (r_threshold),
        .i_opacity   (r_opacity),
        .o_valid     (w_f_valid),
        .o_item      (w_f_item)
    );

    gtb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_item)
    );

    gtb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_luma    (o_luma_out),
        .o_cb      (o_cb_out),
        .o_cr      (o_cr_out),
        .o_mask    (o_mask_level),
        .o_above   (o_above_threshold)
    );

endmodule

// File: sim/glow_threshold_and_blend_test.sv
module glow_threshold_and_blend_test;
    import gtb_pkg::*;

    // One pixel as offered on the input channel
    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic [7:0] bloom;
        logic       region;
    } pixel_t;

    // One processed pixel as seen on the output channel
    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic [7:0] mask;
        logic       above;
    } glow_px_t;

    localparam int DRAIN_CYCLES = 40;    // idle clocks after the last expected word is checked
    localparam int STALL_LIMIT  = 3000;  // idle cycles before giving up

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_luma_in;
    logic [7:0] i_cb_in;
    logic [7:0] i_cr_in;
    logic [7:0] i_bloom_sample;
    logic       i_in_region;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_luma_out;
    logic [7:0] o_cb_out;
    logic [7:0] o_cr_out;
    logic [7:0] o_mask_level;
    logic       o_above_threshold;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    glow_threshold_and_blend DUT (.*);

    always #5 i_clk = ~i_clk;

    // Own gamma tables and register shadow
    logic [9:0] gamma_lin [256];
    logic [7:0] gamma_inv [1024];
    logic [2:0] cfg_mode;
    logic [7:0] cfg_opacity;
    logic [7:0] cfg_threshold;

    pixel_t   pixels_pending [$];
    glow_px_t glow_expected  [$];
    int       fail_count = 0;
    bit       steady = 1'b0;      // no idling in the final stretch
    bit       running = 1'b0;
    int       quiet_cycles = 0;

    function automatic logic [191:0] big_pow(logic [191:0] b, int e);
        logic [191:0] r;
        r = 1;
        repeat (e) r = r * b;
        return r;
    endfunction

    // Exactly rounded gamma tables by bisection on integer powers
    task automatic build_gamma_tables();
        logic [191:0] lim;
        int lo, hi, mid;
        for (int i = 0; i < 256; i++) begin
            lim = big_pow(192'(i), 11) * big_pow(192'(2046), 5);
            lo = 0;
            hi = 1023;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (big_pow(192'(2 * mid - 1), 5) * big_pow(192'(255), 11) <= lim) lo = mid;
                else hi = mid - 1;
            end
            gamma_lin[i] = 10'(lo);
        end
        for (int i = 0; i < 1024; i++) begin
            lim = big_pow(192'(i), 5) * big_pow(192'(510), 11);
            lo = 0;
            hi = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (big_pow(192'(2 * mid - 1), 11) * big_pow(192'(1023), 5) <= lim) lo = mid;
                else hi = mid - 1;
            end
            gamma_inv[i] = 8'(lo);
        end
    endtask

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [7:0] chroma_push(logic [7:0] c, int glow);
        int u, q;
        u = int'(c) - 128;
        q = ((u * glow + 32768) >>> 9) - 64;   // floor division by 512
        return 8'(clip(128 + u + q, 0, 255));
    endfunction

    function automatic glow_px_t glow_blend(pixel_t px);
        glow_px_t res;
        int t, v, mask, glow, den, x, knee, k, sm, a, b, s, r;
        t = int'(cfg_threshold) * 4 + 16;
        v = int'(gamma_lin[px.luma]) - t;
        mask = 0;
        if (v > 0) begin
            den = 1023 - (t >>> 1);
            if (den < 128) den = 128;
            x = (v * 256) / den;
            if (x > 320) x = 320;
            x = x + ((x * x) >>> 8);
            if (x > 512) x = 512;
            knee = (t >>> 1) + 16;
            k = (v * 256) / knee;
            if (k > 256) k = 256;
            sm = (k * k * (768 - 2 * k)) >>> 16;
            x = ((x * sm) >>> 8) >>> 1;
            mask = x > 255 ? 255 : x;
        end
        glow = mask + int'(px.bloom);
        if (glow > 255) glow = 255;
        glow = (glow * int'(cfg_opacity)) >>> 8;
        res.luma = px.luma;
        res.cb = px.cb;
        res.cr = px.cr;
        res.mask = 8'(mask);
        res.above = v > 0;
        if (px.region && glow > 0) begin
            a = gamma_lin[px.luma];
            b = gamma_lin[glow];
            s = a + b;
            case (cfg_mode)
                MODE_ADD:      r = s;
                MODE_SCREEN:   r = 1023 - (((1023 - a) * (1023 - b)) >>> 10);
                MODE_SOFT:     r = int'(px.luma) + glow + ((int'(px.luma) * glow) >>> 8);
                MODE_FILMIC:   r = (s * 1024) / (s + 1023);
                MODE_COMPRESS: r = s - ((s * s) >>> 11);
                default:       r = a + ((b * (1023 - a)) >>> 10);   // six, seven too
            endcase
            if (cfg_mode == MODE_SOFT) res.luma = 8'(clip(r, 0, 255));
            else res.luma = gamma_inv[clip(r, 0, 1023)];
            res.cb = chroma_push(px.cb, glow);
            res.cr = chroma_push(px.cr, glow);
        end
        return res;
    endfunction

    // Driver: pops pending words, idles in random bursts
    int drv_gap = 0;
    always @(posedge i_clk) begin
        logic   nv;
        pixel_t px;
        nv = i_in_valid;
        if (running) begin
            if (i_in_valid && o_in_ready) begin
                glow_expected.push_back(glow_blend('{i_luma_in, i_cb_in, i_cr_in,
                                                     i_bloom_sample, i_in_region}));
                nv = 1'b0;
            end
            if (!nv) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                end else if (pixels_pending.size() > 0) begin
                    if (!steady && $urandom_range(7) == 0) begin
                        drv_gap <= $urandom_range(1, 13);
                    end else begin
                        px = pixels_pending.pop_front();
                        nv = 1'b1;
                        i_luma_in <= px.luma;
                        i_cb_in <= px.cb;
                        i_cr_in <= px.cr;
                        i_bloom_sample <= px.bloom;
                        i_in_region <= px.region;
                    end
                end
            end
        end
        i_in_valid <= nv;
    end

    // Monitor: random receiver stalls, compares each word with the oldest prediction
    int mon_gap = 0;
    always @(posedge i_clk) begin
        glow_px_t w;
        if (running) begin
            if (o_out_valid && i_out_ready) begin
                if (glow_expected.size() == 0) begin
                    $error("output word with no prediction waiting");
                    fail_count++;
                end else begin
                    w = glow_expected.pop_front();
                    if (o_luma_out !== w.luma) begin
                        $error("luma_out expected %0d actual %0d", w.luma, o_luma_out);
                        fail_count++;
                    end
                    if (o_cb_out !== w.cb) begin
                        $error("cb_out expected %0d actual %0d", w.cb, o_cb_out);
                        fail_count++;
                    end
                    if (o_cr_out !== w.cr) begin
                        $error("cr_out expected %0d actual %0d", w.cr, o_cr_out);
                        fail_count++;
                    end
                    if (o_mask_level !== w.mask) begin
                        $error("mask_level expected %0d actual %0d", w.mask, o_mask_level);
                        fail_count++;
                    end
                    if (o_above_threshold !== w.above) begin
                        $error("above_threshold expected %0d actual %0d",
                               w.above, o_above_threshold);
                        fail_count++;
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!steady && $urandom_range(7) == 0) begin
                mon_gap <= $urandom_range(0, 12);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (running) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_MODE:      cfg_mode = val[2:0];
            CFG_OPACITY:   cfg_opacity = val;
            default:       cfg_threshold = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // checked mid-cycle so the driver's updates of this edge are settled
    task automatic drain();
        @(negedge i_clk);
        while (pixels_pending.size() > 0 || i_in_valid || glow_expected.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t px;
        // bias toward bright pixels so the threshold path is exercised
        px.luma = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom);
        px.cb = 8'($urandom);
        px.cr = 8'($urandom);
        px.bloom = 8'($urandom);
        px.region = $urandom_range(3) != 0;
        return px;
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_out_ready <= 1'b0;
        i_luma_in <= '0;
        i_cb_in <= '0;
        i_cr_in <= '0;
        i_bloom_sample <= '0;
        i_in_region <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_MODE;
        i_cfg_data <= '0;
        cfg_mode = MODE_ADD;
        cfg_opacity = 8'd25;
        cfg_threshold = 8'd160;
        build_gamma_tables();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running = 1'b1;

        // Directed words at reset settings: field extremes, region off, zero bloom
        pixels_pending.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
        pixels_pending.push_back('{8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
        pixels_pending.push_back('{8'd255, 8'd0, 8'd255, 8'd0, 1'b1});
        pixels_pending.push_back('{8'd255, 8'd128, 8'd128, 8'd255, 1'b0});
        pixels_pending.push_back('{8'd100, 8'd0, 8'd255, 8'd0, 1'b1});
        pixels_pending.push_back('{8'd0, 8'd255, 8'd0, 8'd255, 1'b1});
        drain();

        // Every mode code, six and seven included, with a bright and a dark pixel
        for (int m = 0; m < 8; m++) begin
            write_reg(CFG_MODE, 8'(m));
            write_reg(CFG_OPACITY, 8'd255);
            write_reg(CFG_THRESHOLD, 8'd0);
            pixels_pending.push_back('{8'd240, 8'd10, 8'd250, 8'd200, 1'b1});
            pixels_pending.push_back('{8'd30, 8'd255, 8'd0, 8'd255, 1'b1});
            drain();
        end
        // Opacity zero still reports mask and flag; top threshold
        write_reg(CFG_OPACITY, 8'd0);
        pixels_pending.push_back('{8'd255, 8'd0, 8'd255, 8'd255, 1'b1});
        drain();
        write_reg(CFG_THRESHOLD, 8'd255);
        pixels_pending.push_back('{8'd255, 8'd0, 8'd255, 8'd255, 1'b1});
        drain();

        // Random phases; the first few pin extreme settings
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_MODE, 8'(MODE_ADD));
                    write_reg(CFG_OPACITY, 8'd255);
                    write_reg(CFG_THRESHOLD, 8'd0);
                end
                1: begin
                    write_reg(CFG_MODE, 8'(MODE_ENERGY));
                    write_reg(CFG_OPACITY, 8'd1);
                    write_reg(CFG_THRESHOLD, 8'd255);
                end
                2: begin
                    write_reg(CFG_MODE, 8'(MODE_SOFT));
                    write_reg(CFG_OPACITY, 8'd0);
                    write_reg(CFG_THRESHOLD, 8'd100);
                end
                default: begin
                    write_reg(CFG_MODE, 8'($urandom_range(7)));
                    write_reg(CFG_OPACITY, 8'($urandom));
                    write_reg(CFG_THRESHOLD, 8'($urandom_range(0, 200)));
                end
            endcase
            if (ph == 11) steady = 1'b1;
            repeat (90) pixels_pending.push_back(rand_pixel());
            drain();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
